@@ rtl/core/sbo_pkg.sv @@
package sbo_pkg;

  // default geometry widths and table size
  localparam int unsigned SBO_COORD_BITS       = 24;
  localparam int unsigned SBO_SIZE_BITS        = 16;
  localparam int unsigned SBO_ANGLE_BITS       = 16;
  localparam int unsigned SBO_SINE_TABLE_DEPTH = 256;

  // sine samples are unsigned q1.15, 32768 is one
  localparam int unsigned SINE_BITS  = 16;
  localparam int unsigned SINE_ONE   = 32768;
  localparam int unsigned ROUND_HALF = 16384;
  localparam int unsigned FRAC_SHIFT = 15;

  // odd polynomial coefficients for a quarter wave, q30
  localparam longint unsigned Q30_C1 = 64'd1686629713;
  localparam longint unsigned Q30_C3 = 64'd693598670;
  localparam longint unsigned Q30_C5 = 64'd85569306;
  localparam longint unsigned Q30_C7 = 64'd5026996;
  localparam longint unsigned Q30_C9 = 64'd172272;

  // quarter wave sample at q30 phase t, rounded to q15 and saturated at one
  function automatic logic [SINE_BITS-1:0] quarter_sine(input longint unsigned t);
    longint unsigned t2;
    longint unsigned p;
    longint unsigned v;
    t2 = (t * t) >> 30;
    p  = Q30_C9;
    p  = Q30_C7 - ((p * t2) >> 30);
    p  = Q30_C5 - ((p * t2) >> 30);
    p  = Q30_C3 - ((p * t2) >> 30);
    p  = Q30_C1 - ((p * t2) >> 30);
    v  = (((p * t) >> 30) + 64'(ROUND_HALF)) >> FRAC_SHIFT;
    if (v > 64'(SINE_ONE)) begin
      v = 64'(SINE_ONE);
    end
    return v[SINE_BITS-1:0];
  endfunction

endpackage

@@ rtl/core/sphere_box_overlap_test.sv @@
// channel  direction  handshake                  payload
// in       input      in_valid_i / in_stall_o    func, shape_kind, center_x/y/z, size_x/y/z, angle
// out      output     out_valid_o / out_stall_i  overlap
//
// a load item is taken without stalling the input and gives no result.
// a test item stalls the input; each box among probe and reference adds a pass through the sine and
// extent states, set by the one shared multiplier and the single sine rom read port.
// in_stall_o is high from acceptance until the result is in the output register.
// reset clears the sequencer and sets the reference to a zero-radius sphere at the origin.
// a stalled result holds, a finished test waits for the output register to free.
module sphere_box_overlap_test
  import sbo_pkg::*;
#(
  parameter int unsigned COORD_BITS       = SBO_COORD_BITS,
  parameter int unsigned SIZE_BITS        = SBO_SIZE_BITS,
  parameter int unsigned ANGLE_BITS       = SBO_ANGLE_BITS,
  parameter int unsigned SINE_TABLE_DEPTH = SBO_SINE_TABLE_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         func_i,
  input  logic                         shape_kind_i,
  input  logic signed [COORD_BITS-1:0] center_x_i,
  input  logic signed [COORD_BITS-1:0] center_y_i,
  input  logic signed [COORD_BITS-1:0] center_z_i,
  input  logic [SIZE_BITS-1:0]         size_x_i,
  input  logic [SIZE_BITS-1:0]         size_y_i,
  input  logic [SIZE_BITS-1:0]         size_z_i,
  input  logic [ANGLE_BITS-1:0]        angle_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         overlap_o
);

  localparam int unsigned KW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned IW = $clog2(4 * SINE_TABLE_DEPTH);
  localparam int unsigned XW = ANGLE_BITS + IW;
  localparam int unsigned CW = COORD_BITS + 1;
  localparam int unsigned HW = SIZE_BITS + 2;
  localparam int unsigned DW = SIZE_BITS + 2;
  localparam int unsigned MW = (SIZE_BITS + 2 > SINE_BITS) ? SIZE_BITS + 2 : SINE_BITS;
  localparam int unsigned PW = 2 * MW;
  localparam int unsigned SW = PW + 2;

  localparam logic [IW-1:0] Quad1 = IW'(SINE_TABLE_DEPTH);
  localparam logic [IW-1:0] Quad2 = IW'(2 * SINE_TABLE_DEPTH);
  localparam logic [IW-1:0] Quad3 = IW'(3 * SINE_TABLE_DEPTH);
  localparam logic [XW-1:0] IdxScale = XW'(4 * SINE_TABLE_DEPTH);
  localparam logic [KW-1:0] StepEnd = KW'(SINE_TABLE_DEPTH);
  localparam logic [1:0]    LastAxis = 2'd2;
  localparam logic          ShapeProbe = 1'b0;
  localparam logic          ShapeRef = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SIN_A,
    ST_SIN_B,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_MUL_END,
    ST_AXIS,
    ST_RAD,
    ST_CMP
  } state_e;

  state_e state_q;
  logic   sel_q;
  logic [1:0] ax_q;
  logic   out_valid_q, overlap_q;

  // reference shape
  logic                         held_kind_q;
  logic signed [COORD_BITS-1:0] held_center_x_q, held_center_y_q, held_center_z_q;
  logic [SIZE_BITS-1:0]         held_size_x_q, held_size_y_q, held_size_z_q;
  logic [ANGLE_BITS-1:0]        held_angle_q;

  // working copies, index 0 probe, index 1 reference
  logic [1:0]           kind_q;
  logic signed [CW-1:0] c_q [2][3];
  logic [HW-1:0]        h_q [2][3];
  logic [SIZE_BITS-1:0] sx_q [2];
  logic [SIZE_BITS-1:0] sz_q [2];
  logic [ANGLE_BITS-1:0] ang_q [2];
  logic [SINE_BITS-1:0] sin_a_q;
  logic [SW-1:0]        acc_q, sum_q;
  logic                 miss_q;

  logic accept, load, test;
  logic [XW-1:0] ang_prod;
  logic [IW-1:0] idx, step_full;
  logic [KW-1:0] step, rom_addr;
  logic          quad_odd;
  logic [SINE_BITS-1:0] rom_data, sn, cs;
  logic [SIZE_BITS-1:0] sx_sel, sz_sel;
  logic [SW-1:0] hsum;
  logic [HW-1:0] rad;
  logic [DW-1:0] axis_dist;
  logic          ax_miss, hit;
  logic          mul_en;
  logic [MW-1:0] mul_a, mul_b;
  logic [PW-1:0] prod;

  assign accept = in_valid_i && (state_q == ST_IDLE);
  assign load   = accept && !func_i;
  assign test   = accept && func_i;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign overlap_o   = overlap_q;

  // angle to quadrant and table step for the shape being turned
  assign ang_prod = XW'(ang_q[sel_q]) * IdxScale;
  assign idx      = ang_prod[XW-1:ANGLE_BITS];

  always_comb begin
    if (idx >= Quad3) begin
      step_full = idx - Quad3;
      quad_odd  = 1'b1;
    end else if (idx >= Quad2) begin
      step_full = idx - Quad2;
      quad_odd  = 1'b0;
    end else if (idx >= Quad1) begin
      step_full = idx - Quad1;
      quad_odd  = 1'b1;
    end else begin
      step_full = idx;
      quad_odd  = 1'b0;
    end
  end

  assign step     = step_full[KW-1:0];
  assign rom_addr = (state_q == ST_SIN_A) ? step : StepEnd - step;

  sbo_sine_rom #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_rom (
    .clk_i (clk_i),
    .addr_i(rom_addr),
    .data_o(rom_data)
  );

  // even quadrants read sin at k, odd quadrants swap
  assign sn     = quad_odd ? rom_data : sin_a_q;
  assign cs     = quad_odd ? sin_a_q : rom_data;
  assign sx_sel = sx_q[sel_q];
  assign sz_sel = sz_q[sel_q];
  assign hsum   = acc_q + SW'(prod) + SW'(ROUND_HALF);

  // radius for the sphere cases
  always_comb begin
    if (!kind_q[0] && !kind_q[1]) begin
      rad = HW'(h_q[0][0] + h_q[1][0]);
    end else if (kind_q[0]) begin
      rad = h_q[1][0];
    end else begin
      rad = h_q[0][0];
    end
  end

  sbo_axis #(
    .CW(CW),
    .HW(HW),
    .SIZE_BITS(SIZE_BITS)
  ) u_axis (
    .kind_a_i(kind_q[0]),
    .kind_b_i(kind_q[1]),
    .ca_i    (c_q[0][ax_q]),
    .cb_i    (c_q[1][ax_q]),
    .ha_i    (h_q[0][ax_q]),
    .hb_i    (h_q[1][ax_q]),
    .dist_o  (axis_dist),
    .miss_o  (ax_miss)
  );

  // operand select for the shared multiplier
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (state_q)
      ST_MUL0: begin
        mul_a = MW'(sx_sel);
        mul_b = MW'(cs);
      end
      ST_MUL1: begin
        mul_a = MW'(sz_sel);
        mul_b = MW'(sn);
      end
      ST_MUL2: begin
        mul_a = MW'(sx_sel);
        mul_b = MW'(sn);
      end
      ST_MUL3: begin
        mul_a = MW'(sz_sel);
        mul_b = MW'(cs);
      end
      ST_AXIS: begin
        mul_a = MW'(axis_dist);
        mul_b = MW'(axis_dist);
      end
      ST_RAD: begin
        mul_a = MW'(rad);
        mul_b = MW'(rad);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  sbo_mul #(
    .WIDTH(MW)
  ) u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .prod_o(prod)
  );

  assign hit = !miss_q && ((kind_q[0] && kind_q[1]) || (sum_q < SW'(prod)));

  // sequencer, reference store and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      sel_q           <= ShapeProbe;
      ax_q            <= '0;
      out_valid_q     <= 1'b0;
      overlap_q       <= 1'b0;
      held_kind_q     <= 1'b0;
      held_center_x_q <= '0;
      held_center_y_q <= '0;
      held_center_z_q <= '0;
      held_size_x_q   <= '0;
      held_size_y_q   <= '0;
      held_size_z_q   <= '0;
      held_angle_q    <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != ST_CMP)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (load) begin
            held_kind_q     <= shape_kind_i;
            held_center_x_q <= center_x_i;
            held_center_y_q <= center_y_i;
            held_center_z_q <= center_z_i;
            held_size_x_q   <= size_x_i;
            held_size_y_q   <= size_y_i;
            held_size_z_q   <= size_z_i;
            held_angle_q    <= angle_i;
          end else if (test) begin
            ax_q <= '0;
            if (shape_kind_i) begin
              sel_q   <= ShapeProbe;
              state_q <= ST_SIN_A;
            end else if (held_kind_q) begin
              sel_q   <= ShapeRef;
              state_q <= ST_SIN_A;
            end else begin
              state_q <= ST_AXIS;
            end
          end
        end
        ST_SIN_A:   state_q <= ST_SIN_B;
        ST_SIN_B:   state_q <= ST_MUL0;
        ST_MUL0:    state_q <= ST_MUL1;
        ST_MUL1:    state_q <= ST_MUL2;
        ST_MUL2:    state_q <= ST_MUL3;
        ST_MUL3:    state_q <= ST_MUL_END;
        ST_MUL_END: begin
          if ((sel_q == ShapeProbe) && kind_q[1]) begin
            sel_q   <= ShapeRef;
            state_q <= ST_SIN_A;
          end else begin
            ax_q    <= '0;
            state_q <= ST_AXIS;
          end
        end
        ST_AXIS: begin
          ax_q <= 2'(ax_q + 2'd1);
          if (ax_q == LastAxis) begin
            state_q <= ST_RAD;
          end
        end
        ST_RAD:     state_q <= ST_CMP;
        ST_CMP: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            overlap_q   <= hit;
            state_q     <= ST_IDLE;
          end
        end
        default:    state_q <= ST_IDLE;
      endcase
    end
  end

  // working shapes, extents and sums
  always_ff @(posedge clk_i) begin
    if (test) begin
      kind_q    <= {held_kind_q, shape_kind_i};
      c_q[0][0] <= {center_x_i, 1'b0};
      c_q[0][1] <= {center_y_i, 1'b0};
      c_q[0][2] <= {center_z_i, 1'b0};
      h_q[0][0] <= HW'({size_x_i, 1'b0});
      h_q[0][1] <= HW'(size_y_i);
      h_q[0][2] <= '0;
      sx_q[0]   <= size_x_i;
      sz_q[0]   <= size_z_i;
      ang_q[0]  <= angle_i;
      c_q[1][0] <= {held_center_x_q, 1'b0};
      c_q[1][1] <= {held_center_y_q, 1'b0};
      c_q[1][2] <= {held_center_z_q, 1'b0};
      h_q[1][0] <= HW'({held_size_x_q, 1'b0});
      h_q[1][1] <= HW'(held_size_y_q);
      h_q[1][2] <= '0;
      sx_q[1]   <= held_size_x_q;
      sz_q[1]   <= held_size_z_q;
      ang_q[1]  <= held_angle_q;
      sum_q     <= '0;
      miss_q    <= 1'b0;
    end
    case (state_q)
      ST_SIN_B:   sin_a_q <= rom_data;
      ST_MUL1:    acc_q <= SW'(prod);
      ST_MUL2:    h_q[sel_q][0] <= HW'(hsum >> FRAC_SHIFT);
      ST_MUL3:    acc_q <= SW'(prod);
      ST_MUL_END: h_q[sel_q][2] <= HW'(hsum >> FRAC_SHIFT);
      ST_AXIS: begin
        miss_q <= miss_q | ax_miss;
        if (ax_q != '0) begin
          sum_q <= sum_q + SW'(prod);
        end
      end
      ST_RAD:     sum_q <= sum_q + SW'(prod);
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/core/sbo_sine_rom.sv @@
module sbo_sine_rom
  import sbo_pkg::*;
#(
  parameter int unsigned SINE_TABLE_DEPTH = SBO_SINE_TABLE_DEPTH,
  localparam int unsigned KW = $clog2(SINE_TABLE_DEPTH + 1)
) (
  input  logic                 clk_i,
  input  logic [KW-1:0]        addr_i,
  output logic [SINE_BITS-1:0] data_o
);

  logic [SINE_BITS-1:0] lut [1 << KW];
  logic [SINE_BITS-1:0] data_q;

  // quarter wave samples, zero past the last step
  for (genvar g = 0; g < (1 << KW); g++) begin : g_lut
    if (g <= SINE_TABLE_DEPTH) begin : g_on
      localparam longint unsigned T = (64'(g) << 30) / SINE_TABLE_DEPTH;
      assign lut[g] = quarter_sine(T);
    end else begin : g_off
      assign lut[g] = '0;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    data_q <= lut[addr_i];
  end

  assign data_o = data_q;

endmodule

@@ rtl/core/sbo_mul.sv @@
module sbo_mul #(
  parameter int unsigned WIDTH = 18
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [WIDTH-1:0]   a_i,
  input  logic [WIDTH-1:0]   b_i,
  output logic [2*WIDTH-1:0] prod_o
);

  logic [2*WIDTH-1:0] prod_q;

  // product registered, held while idle
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_i;
    end
  end

  assign prod_o = prod_q;

endmodule

@@ rtl/core/sbo_axis.sv @@
module sbo_axis #(
  parameter int unsigned CW = 25,
  parameter int unsigned HW = 18,
  parameter int unsigned SIZE_BITS = 16,
  localparam int unsigned DW = SIZE_BITS + 2
) (
  input  logic                 kind_a_i,
  input  logic                 kind_b_i,
  input  logic signed [CW-1:0] ca_i,
  input  logic signed [CW-1:0] cb_i,
  input  logic [HW-1:0]        ha_i,
  input  logic [HW-1:0]        hb_i,
  output logic [DW-1:0]        dist_o,
  output logic                 miss_o
);

  localparam int unsigned AW = ((CW > HW) ? CW : HW) + 3;
  localparam logic signed [AW-1:0] GapLimit = AW'(1) << (SIZE_BITS + 2);

  logic signed [AW-1:0] ca, cb, ha, hb;
  logic signed [AW-1:0] box_c, box_h, pt, lo, hi, delta;
  logic                 sep, gap;

  assign ca = AW'(ca_i);
  assign cb = AW'(cb_i);
  assign ha = AW'(ha_i);
  assign hb = AW'(hb_i);

  // pick the box and the sphere center, two spheres use a zero-size box
  always_comb begin
    if (kind_a_i) begin
      box_c = ca;
      box_h = ha;
      pt    = cb;
    end else begin
      box_c = cb;
      box_h = kind_b_i ? hb : '0;
      pt    = ca;
    end
  end

  // distance from the point to the clamped bound
  assign lo = box_c - box_h;
  assign hi = box_c + box_h;

  always_comb begin
    if (pt < lo) begin
      delta = lo - pt;
    end else if (pt > hi) begin
      delta = pt - hi;
    end else begin
      delta = '0;
    end
  end

  assign gap = (delta >= GapLimit);

  // box against box, touching edges count as overlap
  assign sep = ((ca - ha) > (cb + hb)) || ((ca + ha) < (cb - hb));

  assign miss_o = (kind_a_i && kind_b_i) ? sep : gap;
  assign dist_o = delta[DW-1:0];

endmodule

@@ test/tb_sphere_box_overlap_test.sv @@
module tb_sphere_box_overlap_test
  import sbo_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_W     = SBO_COORD_BITS;
  localparam int SIZE_W      = SBO_SIZE_BITS;
  localparam int ANGLE_W     = SBO_ANGLE_BITS;
  localparam longint unsigned TAB_DEPTH = SBO_SINE_TABLE_DEPTH;
  localparam int CLK_PERIOD  = 10;
  localparam int RESET_CYCLES = 5;
  localparam int RAND_ITEMS  = 600;
  localparam int DRAIN_EVERY = 200;
  localparam int SETTLE_CYCLES = 50;
  localparam int CYCLE_LIMIT = 500000;
  localparam int MAX_REPORTS = 10;

  // item codes
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_TEST   = 1'b1;
  localparam logic KIND_SPHERE = 1'b0;
  localparam logic KIND_BOX    = 1'b1;
  localparam logic BY_TABLE    = 1'b1;
  localparam logic BY_PREDICT  = 1'b0;

  // odd series for a quarter sine wave, q30
  localparam longint unsigned WAVE_K1 = 64'd1686629713;
  localparam longint unsigned WAVE_K3 = 64'd693598670;
  localparam longint unsigned WAVE_K5 = 64'd85569306;
  localparam longint unsigned WAVE_K7 = 64'd5026996;
  localparam longint unsigned WAVE_K9 = 64'd172272;
  localparam longint GAP_LIMIT = longint'(1) << (SIZE_W + 2);

  typedef struct packed {
    logic                      func;
    logic                      kind;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
    logic [SIZE_W-1:0]         sx;
    logic [SIZE_W-1:0]         sy;
    logic [SIZE_W-1:0]         sz;
    logic [ANGLE_W-1:0]        ang;
  } shape_item_t;

  typedef struct packed {
    shape_item_t item;
    logic        has_fixed;
    logic        fixed_hit;
  } table_row_t;

  // axis-aligned bound in half units of the input coordinates
  typedef struct {
    logic   kind;
    longint c[3];
    longint h[3];
  } bound_t;

  typedef enum int {STALL_NONE, STALL_COIN, STALL_COMB} stall_mode_e;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic                      func_i = FUNC_LOAD;
  logic                      shape_kind_i = KIND_SPHERE;
  logic signed [COORD_W-1:0] center_x_i = '0;
  logic signed [COORD_W-1:0] center_y_i = '0;
  logic signed [COORD_W-1:0] center_z_i = '0;
  logic [SIZE_W-1:0]         size_x_i = '0;
  logic [SIZE_W-1:0]         size_y_i = '0;
  logic [SIZE_W-1:0]         size_z_i = '0;
  logic [ANGLE_W-1:0]        angle_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic                      overlap_o;

  shape_item_t stored_shape = '0;
  logic        overlap_due_q [$];
  int          fail_count = 0;
  int          cycle_count = 0;
  int          burst_left = 0;
  stall_mode_e stall_mode = STALL_NONE;
  int          stall_left = 0;
  int          stall_phase = 0;
  table_row_t  dir_tab [25];

  sphere_box_overlap_test i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .shape_kind_i(shape_kind_i),
    .center_x_i  (center_x_i),
    .center_y_i  (center_y_i),
    .center_z_i  (center_z_i),
    .size_x_i    (size_x_i),
    .size_y_i    (size_y_i),
    .size_z_i    (size_z_i),
    .angle_i     (angle_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .overlap_o   (overlap_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // quarter wave sample k of the table, q15 saturated at one
  function automatic longint unsigned wave_sample(longint unsigned k);
    longint unsigned ph, ph2, acc, v;
    ph  = (k << 30) / TAB_DEPTH;
    ph2 = (ph * ph) >> 30;
    acc = WAVE_K9;
    acc = WAVE_K7 - ((acc * ph2) >> 30);
    acc = WAVE_K5 - ((acc * ph2) >> 30);
    acc = WAVE_K3 - ((acc * ph2) >> 30);
    acc = WAVE_K1 - ((acc * ph2) >> 30);
    v   = (((acc * ph) >> 30) + 64'd16384) >> 15;
    if (v > 64'd32768) begin
      v = 64'd32768;
    end
    return v;
  endfunction

  // centers doubled, sphere radius doubled, turned box widened to its bound
  function automatic bound_t make_bound(shape_item_t s);
    bound_t          b;
    longint unsigned idx, k, s_lo, s_hi, sn, cs;
    b.kind = s.kind;
    b.c[0] = 2 * longint'($signed(s.cx));
    b.c[1] = 2 * longint'($signed(s.cy));
    b.c[2] = 2 * longint'($signed(s.cz));
    if (s.kind == KIND_SPHERE) begin
      b.h[0] = 2 * longint'(s.sx);
      b.h[1] = 0;
      b.h[2] = 0;
    end else begin
      idx  = (64'(s.ang) * 64'd4 * TAB_DEPTH) >> ANGLE_W;
      k    = idx % TAB_DEPTH;
      s_lo = wave_sample(k);
      s_hi = wave_sample(TAB_DEPTH - k);
      if (((idx / TAB_DEPTH) & 64'd1) == 64'd1) begin
        sn = s_hi;
        cs = s_lo;
      end else begin
        sn = s_lo;
        cs = s_hi;
      end
      b.h[0] = longint'((64'(s.sx) * cs + 64'(s.sz) * sn + 64'd16384) >> 15);
      b.h[1] = longint'(s.sy);
      b.h[2] = longint'((64'(s.sx) * sn + 64'(s.sz) * cs + 64'd16384) >> 15);
    end
    return b;
  endfunction

  // ball center clamped into the box, strict radius test
  function automatic logic box_ball_hit(bound_t bx, bound_t ball);
    longint lo, hi, p, q, d, sum;
    int     i;
    sum = 0;
    for (i = 0; i < 3; i++) begin
      lo = bx.c[i] - bx.h[i];
      hi = bx.c[i] + bx.h[i];
      p  = ball.c[i];
      q  = (p < lo) ? lo : ((p > hi) ? hi : p);
      d  = (p > q) ? p - q : q - p;
      if (d >= GAP_LIMIT) begin
        return 1'b0;
      end
      sum += d * d;
    end
    return sum < ball.h[0] * ball.h[0];
  endfunction

  // loads update the stored shape, tests return the overlap bit
  function automatic logic predict_overlap(shape_item_t it);
    bound_t pb, rb;
    longint r, d, sum;
    int     i;
    if (it.func == FUNC_LOAD) begin
      stored_shape = it;
      return 1'b0;
    end
    pb = make_bound(it);
    rb = make_bound(stored_shape);
    if (pb.kind == KIND_SPHERE && rb.kind == KIND_SPHERE) begin
      r   = pb.h[0] + rb.h[0];
      sum = 0;
      for (i = 0; i < 3; i++) begin
        d = (pb.c[i] > rb.c[i]) ? pb.c[i] - rb.c[i] : rb.c[i] - pb.c[i];
        if (d >= GAP_LIMIT) begin
          return 1'b0;
        end
        sum += d * d;
      end
      return sum < r * r;
    end else if (pb.kind == KIND_BOX && rb.kind == KIND_BOX) begin
      for (i = 0; i < 3; i++) begin
        if (pb.c[i] - pb.h[i] > rb.c[i] + rb.h[i] ||
            pb.c[i] + pb.h[i] < rb.c[i] - rb.h[i]) begin
          return 1'b0;
        end
      end
      return 1'b1;
    end else if (pb.kind == KIND_BOX) begin
      return box_ball_hit(pb, rb);
    end
    return box_ball_hit(rb, pb);
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 3))
      0: return COORD_W'($urandom);
      1: return COORD_W'($urandom_range(0, 1) ? {1'b0, {(COORD_W-1){1'b1}}}
                                              : {1'b1, {(COORD_W-1){1'b0}}});
      default: return COORD_W'($urandom_range(0, 131072)) - COORD_W'(65536);
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 1) ? {SIZE_W{1'b1}} : {SIZE_W{1'b0}};
      1: return SIZE_W'($urandom_range(0, 255));
      2: return SIZE_W'($urandom_range(0, 4095));
      default: return SIZE_W'($urandom);
    endcase
  endfunction

  function automatic logic [ANGLE_W-1:0] pick_angle();
    if ($urandom_range(0, 3) == 0) begin
      return ANGLE_W'($urandom_range(0, 3)) << (ANGLE_W - 2);
    end
    return ANGLE_W'($urandom);
  endfunction

  function automatic int largest_size(shape_item_t s);
    int m;
    m = int'(s.sx);
    if (s.kind == KIND_BOX) begin
      if (int'(s.sy) > m) m = int'(s.sy);
      if (int'(s.sz) > m) m = int'(s.sz);
    end
    return m;
  endfunction

  task automatic note_failure(input string what);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("[%0t] %s", $realtime, what);
    end
  endtask

  // drive one item in bursts with random gaps, predict at acceptance
  task automatic issue_item(input shape_item_t it, input logic has_fixed, input logic fixed_hit);
    int   gap;
    logic hit;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    func_i       <= it.func;
    shape_kind_i <= it.kind;
    center_x_i   <= it.cx;
    center_y_i   <= it.cy;
    center_z_i   <= it.cz;
    size_x_i     <= it.sx;
    size_y_i     <= it.sy;
    size_z_i     <= it.sz;
    angle_i      <= it.ang;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    hit = predict_overlap(it);
    if (it.func == FUNC_TEST) begin
      overlap_due_q.push_back(has_fixed ? fixed_hit : hit);
    end
  endtask

  // hold off the sender until every pending result is out
  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (overlap_due_q.size() != 0);
  endtask

  // receiver stall pattern, changing its style every stretch
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 2));
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    stall_phase = (stall_phase + 1) % 7;
    case (stall_mode)
      STALL_NONE: out_stall_i <= 1'b0;
      STALL_COIN: out_stall_i <= ($urandom_range(0, 1) == 1);
      default:    out_stall_i <= (stall_phase < 3);
    endcase
  end

  // result check against the oldest pending overlap bit
  always @(posedge clk_i) begin
    logic want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (overlap_due_q.size() == 0) begin
        note_failure($sformatf("unexpected result overlap=%0b", overlap_o));
      end else begin
        want = overlap_due_q.pop_front();
        if (overlap_o !== want) begin
          note_failure($sformatf("overlap mismatch: expected %0b got %0b", want, overlap_o));
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    shape_item_t ref_shape;
    shape_item_t probe;
    int          rand_count;
    int          next_drain;
    int          span;
    int          n_tests;

    // directed rows: tests before any load, extremes, touching, turned boxes
    dir_tab = '{
      '{'{FUNC_TEST, KIND_SPHERE, 24'sd0, 24'sd0, 24'sd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        BY_TABLE, 1'b0},
      '{'{FUNC_TEST, KIND_SPHERE, 24'sd0, 24'sd0, 24'sd0, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000},
        BY_TABLE, 1'b1},
      '{'{FUNC_TEST, KIND_BOX, 24'sd0, 24'sd0, 24'sd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000},
        BY_TABLE, 1'b0},
      '{'{FUNC_TEST, KIND_SPHERE, 24'h7FFFFF, 24'sd0, 24'sd0, 16'hFFFF, 16'h0000, 16'h0000,
          16'h0000}, BY_TABLE, 1'b0},
      '{'{FUNC_LOAD, KIND_SPHERE, 24'sd0, 24'sd0, 24'sd0, 16'h0100, 16'hFFFF, 16'hFFFF, 16'hFFFF},
        BY_PREDICT, 1'b0},
      '{'{FUNC_TEST, KIND_SPHERE, 24'sd256, 24'sd0, 24'sd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        BY_PREDICT, 1'b0},
      '{'{FUNC_TEST, KIND_SPHERE, 24'sd255, 24'sd0, 24'sd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        BY_PREDICT, 1'b0},
      '{'{FUNC_TEST, KIND_BOX, 24'sd0, 24'sd0, 24'sd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
        BY_PREDICT, 1'b0},
      '{'{FUNC_TEST, KIND_BOX, 24'h800000, 24'sd0, 24'sd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000},
        BY_TABLE, 1'b0},
      '{'{FUNC_TEST, KIND_SPHERE, 24'sd0, 24'sd0, 24'h800000, 16'hFFFF, 16'h0000, 16'h0000,
          16'h0000}, BY_TABLE, 1'b0},
      '{'{FUNC_LOAD, KIND_BOX, 24'sd0, 24'sd0, 24'sd0, 16'd512, 16'd512, 16'd512, 16'h0000},
        BY_PREDICT, 1'b0},
      '{'{FUNC_TEST, KIND_BOX, 24'sd512, 24'sd0, 24'sd0, 16'd512, 16'd512, 16'd512, 16'h0000},
        BY_PREDICT, 1'b0},
      '{'{FUNC_TEST, KIND_BOX, 24'sd513, 24'sd0, 24'sd0, 16'd512, 16'd512, 16'd512, 16'h0000},
        BY_PREDICT, 1'b0},
      '{'{FUNC_TEST, KIND_BOX, 24'sd0, 24'sd513, 24'sd0, 16'd512, 16'd512, 16'd512, 16'h2000},
        BY_PREDICT, 1'b0},
      '{'{FUNC_TEST, KIND_SPHERE, 24'sd600, 24'sd600, 24'sd600, 16'd200, 16'h0000, 16'h0000,
          16'h0000}, BY_PREDICT, 1'b0},
      '{'{FUNC_TEST, KIND_SPHERE, 24'sd0, 24'sd0, 24'sd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        BY_TABLE, 1'b0},
      '{'{FUNC_LOAD, KIND_BOX, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
          16'h4000}, BY_PREDICT, 1'b0},
      '{'{FUNC_TEST, KIND_BOX, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 16'h0000, 16'h0000, 16'h0000,
          16'hC000}, BY_PREDICT, 1'b0},
      '{'{FUNC_TEST, KIND_SPHERE, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 16'hFFFF, 16'h0000, 16'h0000,
          16'h0000}, BY_PREDICT, 1'b0},
      '{'{FUNC_TEST, KIND_BOX, 24'sd0, 24'sd0, 24'sd0, 16'd100, 16'd100, 16'd100, 16'h8000},
        BY_TABLE, 1'b0},
      '{'{FUNC_LOAD, KIND_BOX, 24'sd0, 24'sd0, 24'sd0, 16'h1234, 16'd100, 16'hFFFF, 16'hFFFF},
        BY_PREDICT, 1'b0},
      '{'{FUNC_TEST, KIND_BOX, 24'sd1000, -24'sd1000, 24'sd1000, 16'h0800, 16'h0400, 16'h0200,
          16'h8000}, BY_PREDICT, 1'b0},
      '{'{FUNC_TEST, KIND_SPHERE, -24'sd2000, 24'sd0, 24'sd3000, 16'h0800, 16'h0000, 16'h0000,
          16'h0000}, BY_PREDICT, 1'b0},
      '{'{FUNC_LOAD, KIND_SPHERE, 24'sd0, 24'sd0, 24'sd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        BY_PREDICT, 1'b0},
      '{'{FUNC_TEST, KIND_SPHERE, 24'sd0, 24'sd0, 24'sd0, 16'h0001, 16'h0000, 16'h0000, 16'h0000},
        BY_PREDICT, 1'b0}
    };

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      issue_item(dir_tab[i].item, dir_tab[i].has_fixed, dir_tab[i].fixed_hit);
    end
    wait_all_results();

    // random part: mostly a load followed by nearby probes, some noise items
    rand_count = 0;
    next_drain = DRAIN_EVERY;
    while (rand_count < RAND_ITEMS) begin
      if ($urandom_range(0, 4) == 0) begin
        probe.func = 1'($urandom_range(0, 1));
        probe.kind = 1'($urandom_range(0, 1));
        probe.cx   = COORD_W'($urandom);
        probe.cy   = COORD_W'($urandom);
        probe.cz   = COORD_W'($urandom);
        probe.sx   = SIZE_W'($urandom);
        probe.sy   = SIZE_W'($urandom);
        probe.sz   = SIZE_W'($urandom);
        probe.ang  = ANGLE_W'($urandom);
        issue_item(probe, BY_PREDICT, 1'b0);
        rand_count++;
      end else begin
        ref_shape.func = FUNC_LOAD;
        ref_shape.kind = 1'($urandom_range(0, 1));
        ref_shape.cx   = pick_coord();
        ref_shape.cy   = pick_coord();
        ref_shape.cz   = pick_coord();
        ref_shape.sx   = pick_size();
        ref_shape.sy   = pick_size();
        ref_shape.sz   = pick_size();
        ref_shape.ang  = pick_angle();
        issue_item(ref_shape, BY_PREDICT, 1'b0);
        rand_count++;
        n_tests = $urandom_range(1, 8);
        repeat (n_tests) begin
          probe.func = FUNC_TEST;
          probe.kind = 1'($urandom_range(0, 1));
          probe.sx   = pick_size();
          probe.sy   = pick_size();
          probe.sz   = pick_size();
          probe.ang  = pick_angle();
          // offsets around the summed sizes give hits and misses alike
          span = largest_size(ref_shape) + largest_size(probe) + 1;
          probe.cx = ref_shape.cx + COORD_W'(int'($urandom_range(0, 2 * span)) - span);
          probe.cy = ref_shape.cy + COORD_W'(int'($urandom_range(0, 2 * span)) - span);
          probe.cz = ref_shape.cz + COORD_W'(int'($urandom_range(0, 2 * span)) - span);
          issue_item(probe, BY_PREDICT, 1'b0);
          rand_count++;
        end
      end
      if (rand_count >= next_drain) begin
        wait_all_results();
        next_drain += DRAIN_EVERY;
      end
    end

    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && overlap_due_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
